>>> rtl/sdc2pcm_pkg.sv
// Shared types, constants and helper functions of the stereo duty-cycle to PCM sampler.
// Used by the controller, the datapath and the top level; depends on nothing else.

package sdc2pcm_pkg;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);

  localparam int unsigned OP_W       = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TOTAL_W    = 33;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned VOL_W      = 9;
  localparam int unsigned PCM_W      = 8;
  localparam int unsigned WIDX_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W     = PERIOD_W + VOL_W;
  localparam int unsigned REM_W      = PERIOD_W + PCM_W;
  localparam int unsigned CNT_W      = $clog2(PCM_W);

  localparam logic [OP_W-1:0] OP_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

  localparam logic [VOL_W-1:0]    VOL_FULL     = 9'd256;
  localparam logic [VOL_W-1:0]    VOL_RESET    = 9'd84;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd136;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now_ticks;
    logic              line_level;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              sample_valid;
    logic [PCM_W-1:0]  left_sample;
    logic [PCM_W-1:0]  right_sample;
    logic [WIDX_W-1:0] write_index;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic lvl_diff;
    logic lvl_update;
    logic end_calc;
    logic close_diff;
    logic close_update;
    logic mul;
    logic sum;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic enabled;
    logic poll_due;
  } dp_status_t;

  function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] total,
                                                 input logic [TIME_W-1:0]  inc);
    logic [TOTAL_W:0] s;
    s = {1'b0, total} + {2'b00, inc};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

>>> rtl/stereo_duty_cycle_to_pcm_sampler_top.sv
// Top level of the stereo duty-cycle to PCM sampler: ports, configuration handshake and wiring.
// Depends on sdc2pcm_pkg, sdc2pcm_ctrl and sdc2pcm_dp.

// Each transfer on the input channel yields exactly one result transfer. A poll that closes a
// sample period runs the restoring divider, which forms both 8-bit samples in parallel, one
// quotient bit per cycle; a level change, a premature poll, an unknown op or a disabled block
// skip the divider. The block takes one item at a time, but accepts the next one while a
// result still waits in the output register. Configuration writes are always accepted and
// should only be issued while the block is idle.

module stereo_duty_cycle_to_pcm_sampler_top import sdc2pcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  sdc2pcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_op_i     (in_data_i.op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sdc2pcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/sdc2pcm_ctrl.sv
// Controller state machine of the sampler: sequences level changes, polls and the divider.
// Depends on sdc2pcm_pkg; drives the datapath through ctrl_cmd_t and reads dp_status_t.

module sdc2pcm_ctrl import sdc2pcm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] in_op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dp_status_t      status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LVL_DIF = 4'd1;
  localparam logic [3:0] ST_LVL_UPD = 4'd2;
  localparam logic [3:0] ST_P_END   = 4'd3;
  localparam logic [3:0] ST_P_CHK   = 4'd4;
  localparam logic [3:0] ST_CLOSE   = 4'd5;
  localparam logic [3:0] ST_MUL     = 4'd6;
  localparam logic [3:0] ST_SUM     = 4'd7;
  localparam logic [3:0] ST_DIV     = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!status_i.enabled) begin
            state_d = ST_DONE;
          end else begin
            unique case (in_op_i) inside
              OP_LEFT, OP_RIGHT: state_d = ST_LVL_DIF;
              OP_POLL:           state_d = ST_P_END;
              default:           state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_LVL_DIF: begin
        cmd_o.lvl_diff = 1'b1;
        state_d        = ST_LVL_UPD;
      end
      ST_LVL_UPD: begin
        cmd_o.lvl_update = 1'b1;
        state_d          = ST_DONE;
      end
      ST_P_END: begin
        cmd_o.end_calc = 1'b1;
        state_d        = ST_P_CHK;
      end
      ST_P_CHK: begin
        cmd_o.close_diff = 1'b1;
        state_d          = status_i.poll_due ? ST_CLOSE : ST_DONE;
      end
      ST_CLOSE: begin
        cmd_o.close_update = 1'b1;
        state_d            = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PCM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/sdc2pcm_dp.sv
// Datapath of the sampler: configuration, channel timing state, sample arithmetic and divider.
// Depends on sdc2pcm_pkg; steered by the controller through ctrl_cmd_t.

module sdc2pcm_dp import sdc2pcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output out_item_t             out_data_o
);

  logic                en_q;
  logic [VOL_W-1:0]    vol_q;
  logic [PERIOD_W-1:0] per_q;

  logic [TIME_W-1:0]  rise_l_q, rise_r_q, start_q;
  logic [TOTAL_W-1:0] tot_l_q, tot_r_q;
  logic               high_l_q, high_r_q;
  logic [PTR_W-1:0]   ptr_q;

  in_item_t           item_q;
  logic [TIME_W-1:0]  diff_q, diff_l_q, diff_r_q;
  logic               ge_q, close_l_q, close_r_q;
  logic [TIME_W:0]    end_q;
  logic [PROD_W-1:0]  ph_l_q, ph_r_q, pp_q;
  logic [REM_W-1:0]   rem_l_q, rem_r_q, div_q;
  logic [PCM_W-1:0]   q_l_q, q_r_q;
  out_item_t          res_q, out_q;

  logic [PERIOD_W-1:0] per_eff;
  logic [VOL_W-1:0]    vol_eff;
  logic [PERIOD_W-1:0] h_l, h_r;
  logic [TIME_W-1:0]   rise_sel;
  logic                sel_right;
  logic [TIME_W+1:0]   far_sum;
  logic                far;
  logic [TOTAL_W+2:0]  num_l, num_r;
  logic [TIME_W-1:0]   end_t;

  assign per_eff   = (per_q == '0) ? PERIOD_W'(1) : per_q;
  assign vol_eff   = (vol_q > VOL_FULL) ? VOL_FULL : vol_q;
  assign sel_right = (item_q.op == OP_RIGHT);
  assign rise_sel  = sel_right ? rise_r_q : rise_l_q;
  assign end_t     = end_q[TIME_W-1:0];
  assign h_l = (tot_l_q > TOTAL_W'(per_eff)) ? per_eff : tot_l_q[PERIOD_W-1:0];
  assign h_r = (tot_r_q > TOTAL_W'(per_eff)) ? per_eff : tot_r_q[PERIOD_W-1:0];

  assign num_l = (36'(ph_l_q) << 9) - (36'(ph_l_q) << 1) + (36'(pp_q) << 8) - 36'(pp_q);
  assign num_r = (36'(ph_r_q) << 9) - (36'(ph_r_q) << 1) + (36'(pp_q) << 8) - 36'(pp_q);

  assign far_sum = {2'b00, end_t} + {1'b0, 16'(0), per_eff, 1'b0};
  assign far     = far_sum < {2'b00, item_q.now_ticks};

  assign status_o.enabled  = en_q;
  assign status_o.poll_due = {1'b0, item_q.now_ticks} >= end_q;
  assign out_data_o        = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      vol_q    <= VOL_RESET;
      per_q    <= PERIOD_RESET;
      rise_l_q <= '0;
      rise_r_q <= '0;
      tot_l_q  <= '0;
      tot_r_q  <= '0;
      high_l_q <= 1'b0;
      high_r_q <= 1'b0;
      start_q  <= '0;
      ptr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENABLE: en_q  <= cfg_data_i[0];
          CFG_VOLUME: vol_q <= cfg_data_i[VOL_W-1:0];
          CFG_PERIOD: per_q <= cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.lvl_update) begin
        if (sel_right) begin
          high_r_q <= item_q.line_level;
          if (item_q.line_level) begin
            rise_r_q <= item_q.now_ticks;
          end else if (ge_q) begin
            tot_r_q <= add_sat(tot_r_q, diff_q);
          end
        end else begin
          high_l_q <= item_q.line_level;
          if (item_q.line_level) begin
            rise_l_q <= item_q.now_ticks;
          end else if (ge_q) begin
            tot_l_q <= add_sat(tot_l_q, diff_q);
          end
        end
      end
      if (cmd_i.close_update) begin
        if (close_l_q) begin
          tot_l_q  <= add_sat(tot_l_q, diff_l_q);
          rise_l_q <= end_t;
        end
        if (close_r_q) begin
          tot_r_q  <= add_sat(tot_r_q, diff_r_q);
          rise_r_q <= end_t;
        end
      end
      if (cmd_i.sum) begin
        tot_l_q <= '0;
        tot_r_q <= '0;
        start_q <= far ? item_q.now_ticks : end_t;
        ptr_q   <= (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
      res_q  <= {!en_q, 1'b0, PCM_W'(0), PCM_W'(0), WIDX_W'(0)};
      q_l_q  <= '0;
      q_r_q  <= '0;
    end
    if (cmd_i.lvl_diff) begin
      diff_q <= item_q.now_ticks - rise_sel;
      ge_q   <= item_q.now_ticks >= rise_sel;
    end
    if (cmd_i.end_calc) begin
      end_q <= {1'b0, start_q} + {17'(0), per_eff};
    end
    if (cmd_i.close_diff) begin
      diff_l_q  <= end_t - rise_l_q;
      diff_r_q  <= end_t - rise_r_q;
      close_l_q <= high_l_q && (end_t > rise_l_q);
      close_r_q <= high_r_q && (end_t > rise_r_q);
    end
    if (cmd_i.mul) begin
      ph_l_q <= PROD_W'(h_l) * PROD_W'(vol_eff);
      ph_r_q <= PROD_W'(h_r) * PROD_W'(vol_eff);
      pp_q   <= PROD_W'(VOL_FULL - vol_eff) * PROD_W'(per_eff);
    end
    if (cmd_i.sum) begin
      rem_l_q <= num_l[REM_W+8:9];
      rem_r_q <= num_r[REM_W+8:9];
      div_q   <= {1'b0, per_eff, 7'd0};
      res_q   <= {res_q.status, 1'b1, res_q.left_sample, res_q.right_sample,
                  WIDX_W'(ptr_q)};
    end
    if (cmd_i.div_step) begin
      if (rem_l_q >= div_q) begin
        rem_l_q <= rem_l_q - div_q;
        q_l_q   <= {q_l_q[PCM_W-2:0], 1'b1};
      end else begin
        q_l_q   <= {q_l_q[PCM_W-2:0], 1'b0};
      end
      if (rem_r_q >= div_q) begin
        rem_r_q <= rem_r_q - div_q;
        q_r_q   <= {q_r_q[PCM_W-2:0], 1'b1};
      end else begin
        q_r_q   <= {q_r_q[PCM_W-2:0], 1'b0};
      end
      div_q <= div_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_q <= {res_q.status, res_q.sample_valid, q_l_q, q_r_q, res_q.write_index};
    end
  end

endmodule

>>> dv/tb_stereo_duty_cycle_to_pcm_sampler_top.sv
// Self-checking testbench for the stereo duty-cycle to PCM sampler top level.
// A queue-fed driver, a checking monitor and a predictor of the value of every result.
// Depends on sdc2pcm_pkg and stereo_duty_cycle_to_pcm_sampler_top.
`timescale 1ns / 100ps

module tb_stereo_duty_cycle_to_pcm_sampler_top;
  import sdc2pcm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned     CYCLE_LIMIT = 300000;
  localparam bit [32:0]       SUM_CAP     = {33{1'b1}};

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data     = '0;
  logic                  out_valid_o;
  logic                  out_ready   = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  stereo_duty_cycle_to_pcm_sampler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirrored configuration and sampler state.
  bit                sound_on    = 1'b1;
  bit [VOL_W-1:0]    swing_q8    = VOL_RESET;
  bit [PERIOD_W-1:0] frame_ticks = PERIOD_RESET;
  bit [TIME_W-1:0]   rise_at[2]    = '{default: '0};
  bit [TOTAL_W-1:0]  high_ticks[2] = '{default: '0};
  bit                line_high[2]  = '{default: 1'b0};
  bit [TIME_W-1:0]   frame_start   = '0;
  bit [WIDX_W-1:0]   slot_ptr      = '0;

  in_item_t  pcm_pending_q[$];
  out_item_t pcm_expected_q[$];
  int        items_queued   = 0;
  int        items_accepted = 0;
  int        mismatch_count = 0;
  int        send_gap       = 0;
  int        recv_gap       = 0;
  int        long_hold      = 0;
  bit        long_hold_req  = 1'b0;
  bit        long_hold_done = 1'b0;
  bit        idle_off       = 1'b0;
  int        cycle_count    = 0;

  bit [TIME_W-1:0] stim_t = '0;
  bit              gen_level[2] = '{default: 1'b0};

  function automatic bit [TOTAL_W-1:0] add_capped(input bit [TOTAL_W-1:0] sum,
                                                  input bit [TIME_W-1:0]  inc);
    bit [TOTAL_W:0] s;
    s = sum + inc;
    return (s > SUM_CAP) ? SUM_CAP : s[TOTAL_W-1:0];
  endfunction

  function automatic bit [PCM_W-1:0] duty_to_pcm(input bit [TOTAL_W-1:0] sum,
                                                 input bit [PERIOD_W:0]  per,
                                                 input bit [VOL_W-1:0]   vol);
    bit [63:0] h;
    bit [63:0] num;
    bit [63:0] q;
    h   = (sum > per) ? per : sum;
    num = 64'd510 * h * vol + 64'd255 * (64'd256 - vol) * per;
    q   = num / (64'd512 * per);
    return (q > 64'd255) ? 8'd255 : q[PCM_W-1:0];
  endfunction

  function automatic out_item_t predict_sample(input in_item_t it);
    out_item_t        res;
    bit [PERIOD_W:0]  per;
    bit [VOL_W-1:0]   vol;
    bit [TIME_W:0]    stop_t;
    int               ch;
    res = '0;
    per = (frame_ticks == 0) ? 17'd1 : {1'b0, frame_ticks};
    vol = (swing_q8 > VOL_FULL) ? VOL_FULL : swing_q8;
    if (!sound_on) begin
      res.status = 1'b1;
      return res;
    end
    if (it.op == OP_LEFT || it.op == OP_RIGHT) begin
      ch = (it.op == OP_RIGHT) ? 1 : 0;
      if (it.line_level) begin
        rise_at[ch] = it.now_ticks;
      end else if (it.now_ticks >= rise_at[ch]) begin
        high_ticks[ch] = add_capped(high_ticks[ch], it.now_ticks - rise_at[ch]);
      end
      line_high[ch] = it.line_level;
      return res;
    end
    if (it.op != OP_POLL) return res;
    stop_t = {1'b0, frame_start} + per;
    if ({1'b0, it.now_ticks} < stop_t) return res;
    for (int c = 0; c < 2; c++) begin
      if (line_high[c] && stop_t[TIME_W-1:0] > rise_at[c]) begin
        high_ticks[c] = add_capped(high_ticks[c], stop_t[TIME_W-1:0] - rise_at[c]);
        rise_at[c]    = stop_t[TIME_W-1:0];
      end
    end
    res.sample_valid = 1'b1;
    res.left_sample  = duty_to_pcm(high_ticks[0], per, vol);
    res.right_sample = duty_to_pcm(high_ticks[1], per, vol);
    res.write_index  = slot_ptr;
    slot_ptr         = (slot_ptr + 1) % RING_DEPTH;
    high_ticks[0]    = '0;
    high_ticks[1]    = '0;
    frame_start      = stop_t[TIME_W-1:0];
    if ({2'b00, frame_start} + {per, 1'b0} < {2'b00, it.now_ticks}) frame_start = it.now_ticks;
    return res;
  endfunction

  // Input driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        pcm_expected_q.push_back(predict_sample(in_data));
        items_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 16);
        end else if (pcm_pending_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pcm_pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready      <= 1'b0;
      recv_gap       <= 0;
      long_hold      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pcm_expected_q.size() == 0) begin
          $error("result transfer with no expected result pending");
          mismatch_count++;
        end else begin
          want = pcm_expected_q.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
            mismatch_count++;
          end
          if (out_data_o.sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0d, actual %0d", want.sample_valid,
                   out_data_o.sample_valid);
            mismatch_count++;
          end
          if (out_data_o.left_sample !== want.left_sample) begin
            $error("left_sample: expected %0d, actual %0d", want.left_sample,
                   out_data_o.left_sample);
            mismatch_count++;
          end
          if (out_data_o.right_sample !== want.right_sample) begin
            $error("right_sample: expected %0d, actual %0d", want.right_sample,
                   out_data_o.right_sample);
            mismatch_count++;
          end
          if (out_data_o.write_index !== want.write_index) begin
            $error("write_index: expected %0d, actual %0d", want.write_index,
                   out_data_o.write_index);
            mismatch_count++;
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        out_ready      <= 1'b0;
        long_hold      <= 400;
        long_hold_done <= 1'b1;
      end else if (long_hold > 0) begin
        out_ready <= 1'b0;
        long_hold <= long_hold - 1;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        recv_gap  <= $urandom_range(0, 16);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                            input logic lvl);
    in_item_t it;
    it.op         = op;
    it.now_ticks  = now;
    it.line_level = lvl;
    pcm_pending_q.push_back(it);
    items_queued++;
  endtask

  task automatic advance_time(input int unsigned d);
    if (stim_t > 32'hFFFF_FFFF - d) stim_t = '1;
    else stim_t = stim_t + d;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLE: sound_on    = data[0];
      CFG_VOLUME: swing_q8    = data[VOL_W-1:0];
      CFG_PERIOD: frame_ticks = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (items_accepted != items_queued || pcm_expected_q.size() != 0);
  endtask

  // Mostly well-formed edge and poll sequences, with stale time stamps and odd ops as noise.
  task automatic queue_random_items(input int n);
    int unsigned per;
    int unsigned r;
    int unsigned ch;
    bit          lvl;
    per = (frame_ticks == 0) ? 1 : frame_ticks;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        ch  = $urandom_range(0, 1);
        lvl = ($urandom_range(0, 9) == 0) ? 1'($urandom_range(0, 1)) : !gen_level[ch];
        advance_time($urandom_range(0, per / 4 + 1));
        queue_item(ch ? OP_RIGHT : OP_LEFT, stim_t, lvl);
        gen_level[ch] = lvl;
      end else if (r < 86) begin
        advance_time($urandom_range(0, per));
        queue_item(OP_POLL, stim_t, 1'($urandom_range(0, 1)));
      end else if (r < 94) begin
        queue_item(2'($urandom_range(0, 3)),
                   stim_t - 32'($urandom_range(0, (stim_t > per) ? per : stim_t)),
                   1'($urandom_range(0, 1)));
      end else begin
        advance_time($urandom_range(2 * per, 5 * per));
        queue_item(OP_POLL, stim_t, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Saturating left total, then a right fall that comes before its rise.
    queue_item(OP_LEFT, 32'd0, 1'b1);
    queue_item(OP_LEFT, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_LEFT, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_LEFT, 32'hFFFF_FFFF, 1'b0);
    queue_item(OP_RIGHT, 32'd20, 1'b1);
    queue_item(OP_RIGHT, 32'd10, 1'b0);
    queue_item(OP_RIGHT, 32'd30, 1'b1);
    queue_item(OP_POLL, 32'd100, 1'b1);
    queue_item(OP_POLL, 32'd136, 1'b0);
    queue_item(OP_LEFT, 32'd150, 1'b1);
    queue_item(OP_LEFT, 32'd200, 1'b0);
    queue_item(OP_UNUSED, 32'd210, 1'b1);
    queue_item(OP_POLL, 32'd271, 1'b0);
    queue_item(OP_POLL, 32'd272, 1'b1);
    queue_item(OP_POLL, 32'd5000, 1'b0);
    wait_drained();

    write_cfg(CFG_ENABLE, 16'd0);
    queue_item(OP_LEFT, 32'd5010, 1'b1);
    queue_item(OP_RIGHT, 32'd5020, 1'b1);
    queue_item(OP_POLL, 32'd6000, 1'b0);
    queue_item(OP_UNUSED, 32'd6001, 1'b0);
    wait_drained();
    stim_t = 32'd6001;

    write_cfg(CFG_ENABLE, 16'd1);
    write_cfg(CFG_VOLUME, 16'd256);
    write_cfg(CFG_PERIOD, 16'd1);
    queue_random_items(60);
    wait_drained();

    write_cfg(CFG_VOLUME, 16'd0);
    write_cfg(CFG_PERIOD, 16'd0);
    queue_random_items(60);
    wait_drained();

    write_cfg(CFG_VOLUME, 16'hFFFF);
    write_cfg(CFG_PERIOD, 16'hFFFF);
    queue_random_items(60);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(CFG_VOLUME, 16'($urandom_range(0, 300)));
      write_cfg(CFG_PERIOD, 16'($urandom_range(1, 400)));
      if (ph == 0) long_hold_req <= 1'b1;
      if (ph == 2) stim_t = 32'h8000_0000 + $urandom_range(0, 32'h00FF_FFFF);
      if (ph == 3) begin
        write_cfg(CFG_ENABLE, 16'($urandom));
        write_cfg(CFG_VOLUME, 16'($urandom));
        write_cfg(CFG_PERIOD, 16'($urandom));
      end
      if (ph == 4) begin
        write_cfg(CFG_ENABLE, 16'd1);
        stim_t = 32'hFFFF_0000;
        idle_off <= 1'b1;
      end
      queue_random_items(80);
      wait_drained();
    end

    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0 && pcm_expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
